FILE: hdl/temc_pkg.sv
// Shared constants for the threshold edge map cleanup block.
package temc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int THR_W      = 16;
    localparam int DIM_CFG_W  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam logic [THR_W-1:0]     THRESHOLD_RESET = 16'd32768;
    localparam logic [DIM_CFG_W-1:0] WIDTH_RESET     = 7'd64;
    localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET    = 7'd64;

    localparam int FUNC_LOAD = 0;

endpackage

FILE: hdl/threshold_edge_map_cleanup_core.sv
// Thresholded 2x2 edge map with diagonal cleanup, top level.
// A read result passes through the registered memory read and ST_RD_WAIT before it is valid,
// or is registered directly if no frame is ready; the next item waits until it leaves.
// The last sample of a frame starts the compute pass: edge detection over all W*H pixels,
// then cleanup over (W-1)*(H-1) windows, each step paced by the single read port.
// aresetn clears control state and configuration to reset values; memory contents stay undefined.
module threshold_edge_map_cleanup_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [temc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [temc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [15:0] s_sample,
    // Result channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_edge_bit,
    output logic [5:0]  m_pixel_x,
    output logic [5:0]  m_pixel_y,
    output logic        m_last_pixel,
    output logic        m_not_ready
);

    localparam int XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int DWX   = $clog2(MAX_WIDTH + 1);
    localparam int DWY   = $clog2(MAX_HEIGHT + 1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RD_WAIT = 4'd1;
    localparam logic [3:0] ST_E_R0    = 4'd2;
    localparam logic [3:0] ST_E_R1    = 4'd3;
    localparam logic [3:0] ST_E_R2    = 4'd4;
    localparam logic [3:0] ST_E_R3    = 4'd5;
    localparam logic [3:0] ST_E_R4    = 4'd6;
    localparam logic [3:0] ST_C_R0    = 4'd7;
    localparam logic [3:0] ST_C_R1    = 4'd8;
    localparam logic [3:0] ST_C_R2    = 4'd9;
    localparam logic [3:0] ST_C_R3    = 4'd10;
    localparam logic [3:0] ST_C_R4    = 4'd11;
    localparam logic [3:0] ST_C_W1    = 4'd12;

    // Two single-bit memories: the thresholded image and the edge map.
    logic bin_mem  [DEPTH];
    logic edge_mem [DEPTH];
    logic bin_rdata_reg, edge_rdata_reg;
    logic [AW-1:0] bin_raddr, edge_raddr, edge_waddr;
    logic bin_we, edge_we, edge_wdata;

    // Configuration registers.
    logic [15:0] thr_reg;
    logic [6:0]  gw_reg, gh_reg;

    // Load-side frame state.
    logic           ld_active_reg;
    logic [15:0]    ld_thr_reg;
    logic [DWX-1:0] ld_w_reg;
    logic [DWY-1:0] ld_h_reg;
    logic [XW-1:0]  ld_x_reg;
    logic [YW-1:0]  ld_y_reg;

    // Readout-side frame state.
    logic           frame_ready_reg;
    logic [DWX-1:0] rd_w_reg;
    logic [DWY-1:0] rd_h_reg;
    logic [XW-1:0]  rd_x_reg;
    logic [YW-1:0]  rd_y_reg;

    // Compute sequencer.
    logic [3:0]    state_reg, state_next;
    logic [XW-1:0] cx_reg;
    logic [YW-1:0] cy_reg;
    logic          v_reg, acc_reg, diag_reg;

    // Result register.
    logic       m_valid_reg;
    logic       m_edge_bit_reg, m_last_pixel_reg, m_not_ready_reg;
    logic [5:0] m_pixel_x_reg, m_pixel_y_reg;

    // Clamped geometry from the configuration registers.
    logic [DWX-1:0] cfg_w;
    logic [DWY-1:0] cfg_h;
    always_comb begin
        if (gw_reg < 7'd2) begin
            cfg_w = DWX'(2);
        end else if (32'(gw_reg) > MAX_WIDTH) begin
            cfg_w = DWX'(MAX_WIDTH);
        end else begin
            cfg_w = DWX'(gw_reg);
        end
        if (gh_reg < 7'd2) begin
            cfg_h = DWY'(2);
        end else if (32'(gh_reg) > MAX_HEIGHT) begin
            cfg_h = DWY'(MAX_HEIGHT);
        end else begin
            cfg_h = DWY'(gh_reg);
        end
    end

    // A frame latches its geometry and threshold on its first sample.
    logic [15:0]    eff_thr;
    logic [DWX-1:0] eff_w;
    logic [DWY-1:0] eff_h;
    logic           ld_last, ld_row_end;
    assign eff_thr    = ld_active_reg ? ld_thr_reg : thr_reg;
    assign eff_w      = ld_active_reg ? ld_w_reg   : cfg_w;
    assign eff_h      = ld_active_reg ? ld_h_reg   : cfg_h;
    assign ld_row_end = (DWX'(ld_x_reg) == eff_w - DWX'(1));
    assign ld_last    = ld_row_end && (DWY'(ld_y_reg) == eff_h - DWY'(1));

    logic accept, is_load;
    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept  = s_valid && s_ready;
    assign is_load = (s_func == 1'(temc_pkg::FUNC_LOAD));

    // Compute pass neighbour tests and cleanup window position.
    logic right_ok, down_ok, e_x_end, e_y_end, c_x_end, c_y_end;
    assign right_ok = (DWX'(cx_reg) != ld_w_reg - DWX'(1));
    assign down_ok  = (DWY'(cy_reg) != ld_h_reg - DWY'(1));
    assign e_x_end  = !right_ok;
    assign e_y_end  = !down_ok;
    assign c_x_end  = (DWX'(cx_reg) == ld_w_reg - DWX'(2));
    assign c_y_end  = (DWY'(cy_reg) == ld_h_reg - DWY'(2));

    logic [XW-1:0] cx_p1;
    logic [YW-1:0] cy_p1;
    assign cx_p1 = cx_reg + XW'(1);
    assign cy_p1 = cy_reg + YW'(1);

    logic rd_row_end, rd_last;
    assign rd_row_end = (DWX'(rd_x_reg) == rd_w_reg - DWX'(1));
    assign rd_last    = rd_row_end && (DWY'(rd_y_reg) == rd_h_reg - DWY'(1));

    // Memory address and write selection for each sequencer step.
    always_comb begin
        bin_raddr  = {cy_reg, cx_reg};
        edge_raddr = {cy_reg, cx_reg};
        edge_waddr = {cy_reg, cx_reg};
        edge_we    = 1'b0;
        edge_wdata = 1'b0;
        bin_we     = accept && is_load;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                edge_raddr = {rd_y_reg, rd_x_reg};
                if (accept) begin
                    if (is_load) begin
                        if (ld_last) begin
                            state_next = ST_E_R0;
                        end
                    end else if (frame_ready_reg) begin
                        state_next = ST_RD_WAIT;
                    end
                end
            end
            ST_RD_WAIT: state_next = ST_IDLE;
            ST_E_R0: state_next = ST_E_R1;
            ST_E_R1: begin
                bin_raddr  = {cy_reg, cx_p1};
                state_next = ST_E_R2;
            end
            ST_E_R2: begin
                bin_raddr  = {cy_p1, cx_reg};
                state_next = ST_E_R3;
            end
            ST_E_R3: begin
                bin_raddr  = {cy_p1, cx_p1};
                state_next = ST_E_R4;
            end
            ST_E_R4: begin
                edge_we    = 1'b1;
                edge_wdata = acc_reg || (right_ok && down_ok && (bin_rdata_reg != v_reg));
                state_next = (e_x_end && e_y_end) ? ST_C_R0 : ST_E_R0;
            end
            ST_C_R0: state_next = ST_C_R1;
            ST_C_R1: begin
                edge_raddr = {cy_p1, cx_p1};
                state_next = ST_C_R2;
            end
            ST_C_R2: begin
                edge_raddr = {cy_reg, cx_p1};
                state_next = ST_C_R3;
            end
            ST_C_R3: begin
                edge_raddr = {cy_p1, cx_reg};
                state_next = ST_C_R4;
            end
            ST_C_R4: begin
                // Window corners: diag_reg holds top-left and bottom-right both set,
                // acc_reg holds top-right, the read data holds bottom-left.
                if (diag_reg) begin
                    edge_we    = 1'b1;
                    edge_waddr = {cy_reg, cx_p1};
                    state_next = ST_C_W1;
                end else if (acc_reg && edge_rdata_reg) begin
                    edge_we    = 1'b1;
                    edge_waddr = {cy_reg, cx_reg};
                    state_next = ST_C_W1;
                end else begin
                    state_next = (c_x_end && c_y_end) ? ST_IDLE : ST_C_R0;
                end
            end
            ST_C_W1: begin
                edge_we    = 1'b1;
                edge_waddr = diag_reg ? {cy_p1, cx_reg} : {cy_p1, cx_p1};
                state_next = (c_x_end && c_y_end) ? ST_IDLE : ST_C_R0;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge aclk) begin
        if (bin_we) begin
            bin_mem[{ld_y_reg, ld_x_reg}] <= (s_sample > eff_thr);
        end
        bin_rdata_reg <= bin_mem[bin_raddr];
        if (edge_we) begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_rdata_reg <= edge_mem[edge_raddr];
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= temc_pkg::THRESHOLD_RESET;
            gw_reg  <= temc_pkg::WIDTH_RESET;
            gh_reg  <= temc_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                temc_pkg::REG_THRESHOLD: thr_reg <= cfg_wdata;
                temc_pkg::REG_WIDTH:     gw_reg  <= cfg_wdata[6:0];
                temc_pkg::REG_HEIGHT:    gh_reg  <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Sequencer, load and readout state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ld_active_reg   <= 1'b0;
            ld_x_reg        <= '0;
            ld_y_reg        <= '0;
            frame_ready_reg <= 1'b0;
            rd_x_reg        <= '0;
            rd_y_reg        <= '0;
            cx_reg          <= '0;
            cy_reg          <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && is_load) begin
                        ld_thr_reg <= eff_thr;
                        ld_w_reg   <= eff_w;
                        ld_h_reg   <= eff_h;
                        if (ld_last) begin
                            ld_active_reg <= 1'b0;
                            ld_x_reg      <= '0;
                            ld_y_reg      <= '0;
                            cx_reg        <= '0;
                            cy_reg        <= '0;
                        end else begin
                            ld_active_reg <= 1'b1;
                            if (ld_row_end) begin
                                ld_x_reg <= '0;
                                ld_y_reg <= ld_y_reg + YW'(1);
                            end else begin
                                ld_x_reg <= ld_x_reg + XW'(1);
                            end
                        end
                    end else if (accept) begin
                        m_pixel_x_reg    <= frame_ready_reg ? 6'(rd_x_reg) : 6'd0;
                        m_pixel_y_reg    <= frame_ready_reg ? 6'(rd_y_reg) : 6'd0;
                        m_last_pixel_reg <= frame_ready_reg && rd_last;
                        m_not_ready_reg  <= !frame_ready_reg;
                        m_edge_bit_reg   <= 1'b0;
                        if (!frame_ready_reg) begin
                            m_valid_reg <= 1'b1;
                        end else if (rd_last) begin
                            rd_x_reg <= '0;
                            rd_y_reg <= '0;
                        end else if (rd_row_end) begin
                            rd_x_reg <= '0;
                            rd_y_reg <= rd_y_reg + YW'(1);
                        end else begin
                            rd_x_reg <= rd_x_reg + XW'(1);
                        end
                    end
                end
                ST_RD_WAIT: begin
                    m_edge_bit_reg <= edge_rdata_reg;
                    m_valid_reg    <= 1'b1;
                end
                ST_E_R1: v_reg <= bin_rdata_reg;
                ST_E_R2: acc_reg <= right_ok && (bin_rdata_reg != v_reg);
                ST_E_R3: acc_reg <= acc_reg || (down_ok && (bin_rdata_reg != v_reg));
                ST_E_R4: begin
                    if (e_x_end) begin
                        cx_reg <= '0;
                        cy_reg <= e_y_end ? '0 : cy_p1;
                    end else begin
                        cx_reg <= cx_p1;
                    end
                end
                ST_C_R1: v_reg <= edge_rdata_reg;
                ST_C_R2: diag_reg <= v_reg && edge_rdata_reg;
                ST_C_R3: acc_reg <= edge_rdata_reg;
                ST_C_R4, ST_C_W1: begin
                    if (state_next == ST_IDLE) begin
                        frame_ready_reg <= 1'b1;
                        rd_w_reg        <= ld_w_reg;
                        rd_h_reg        <= ld_h_reg;
                        rd_x_reg        <= '0;
                        rd_y_reg        <= '0;
                    end
                    if (state_next inside {ST_IDLE, ST_C_R0}) begin
                        if (c_x_end) begin
                            cx_reg <= '0;
                            cy_reg <= cy_p1;
                        end else begin
                            cx_reg <= cx_p1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_edge_bit   = m_edge_bit_reg;
    assign m_pixel_x    = m_pixel_x_reg;
    assign m_pixel_y    = m_pixel_y_reg;
    assign m_last_pixel = m_last_pixel_reg;
    assign m_not_ready  = m_not_ready_reg;

endmodule
